@@ rtl/core/awk_pkg.sv @@
// Shared types, constants and helper functions for the archive block header walker.
package awk_pkg;

    // Width of the file counter; the count shown on the output saturates at 16 bits.
    localparam int COUNT_WIDTH = 16;
    localparam int CNT_EXT_W   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    // Header layout.
    localparam logic [4:0]  SIG_LAST_IDX   = 5'd6;
    localparam logic [4:0]  SIG_LEN        = 5'd7;
    localparam logic [15:0] BASE_LEN       = 16'd7;
    localparam logic [16:0] FILE_HDR_MIN   = 17'd32;
    localparam logic [4:0]  FIX_LAST_IDX   = 5'd24;

    // Block types.
    localparam logic [7:0] TYPE_MAIN = 8'h73;
    localparam logic [7:0] TYPE_FILE = 8'h74;
    localparam logic [7:0] TYPE_END  = 8'h7B;

    // Summary status codes.
    localparam logic [2:0] ST_END_BLOCK = 3'd0;
    localparam logic [2:0] ST_UNKNOWN   = 3'd1;
    localparam logic [2:0] ST_DATA_END  = 3'd2;
    localparam logic [2:0] ST_BAD_SIG   = 3'd3;
    localparam logic [2:0] ST_MALFORMED = 3'd4;

    // Result kinds.
    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue and output packing.
    localparam int QUEUE_DEPTH = 4;
    localparam int TDATA_W     = 32;
    localparam int TDATA_PAD   = TDATA_W - 28;

    // One result item.
    typedef struct packed {
        logic        kind;
        logic [7:0]  name_byte;
        logic        name_end;
        logic [15:0] file_count;
        logic [2:0]  status;
        logic        last;
    } result_t;

    // Results produced by one input transaction; wr1 is only set together with wr0.
    typedef struct packed {
        logic    wr0;
        logic    wr1;
        result_t res0;
        result_t res1;
    } push_t;

    // Expected signature byte at a given position.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            3'd0: b = 8'h52;
            3'd1: b = 8'h61;
            3'd2: b = 8'h72;
            3'd3: b = 8'h21;
            3'd4: b = 8'h1A;
            3'd5: b = 8'h07;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // File count as shown on the output, saturated at 16 bits.
    function automatic logic [15:0] shown_count(input logic [COUNT_WIDTH-1:0] c);
        logic [CNT_EXT_W-1:0] ext;
        ext = CNT_EXT_W'(c);
        if (ext > CNT_EXT_W'(16'hFFFF))
        begin
            return 16'hFFFF;
        end
        return ext[15:0];
    endfunction

endpackage

@@ rtl/core/archive_block_header_walker_unit.sv @@
// Each result is queued as its byte is accepted. Throughput: one byte per cycle while
// s_tready is high; a final name byte gives two results, drained one a cycle on m_tready.
// The slave side is ready while the four-entry result queue has room for two results.
// Reset (rst_n low, asynchronous) returns the walk to the signature check, clears the
// file count and empties the result queue.
module archive_block_header_walker_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] in_byte
    input  logic                        s_tlast,   // end_of_data
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [awk_pkg::TDATA_W-1:0] m_tdata,   // [7:0] name_byte, [8] name_end,
                                                   // [24:9] file_count, [27:25] status
    output logic                        m_tuser,   // kind
    output logic                        m_tlast    // last
);
    import awk_pkg::*;

    logic    in_accept;
    push_t   push;
    result_t out_res;

    assign in_accept = s_tvalid && s_tready;

    // Header walk for each accepted byte.
    awk_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_accept),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .push     (push)
    );

    // Results wait here until the master side takes them.
    awk_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Output packing.
    assign m_tdata = {{TDATA_PAD{1'b0}}, out_res.status, out_res.file_count,
                      out_res.name_end, out_res.name_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

@@ rtl/core/awk_parser.sv @@
// Byte-wise header parser: walk state and the results of each accepted byte.
module awk_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output awk_pkg::push_t   push
);
    import awk_pkg::*;

    typedef enum logic [5:0] {
        PH_SIG  = 6'b000001,
        PH_HDR  = 6'b000010,
        PH_FIX  = 6'b000100,
        PH_NAME = 6'b001000,
        PH_SKIP = 6'b010000,
        PH_DONE = 6'b100000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [4:0]             byte_index_reg, byte_index_next;
    logic [7:0]             block_type_reg, block_type_next;
    logic [15:0]            block_size_reg, block_size_next;
    logic [31:0]            packed_size_reg, packed_size_next;
    logic [15:0]            name_length_reg, name_length_next;
    logic [32:0]            skip_remaining_reg, skip_remaining_next;
    logic [COUNT_WIDTH-1:0] files_seen_reg, files_seen_next;

    logic        stopped;
    logic [2:0]  stop_status;
    logic        name_emit;
    logic [15:0] size_new;
    logic [16:0] fix_total;
    logic [15:0] size_rest;
    logic [32:0] skip_calc;
    logic [15:0] name_dec;
    logic [32:0] skip_dec;
    result_t     name_res;
    result_t     sum_res;

    // Next-state logic for one accepted byte.
    always_comb
    begin
        phase_next          = phase_reg;
        byte_index_next     = byte_index_reg;
        block_type_next     = block_type_reg;
        block_size_next     = block_size_reg;
        packed_size_next    = packed_size_reg;
        name_length_next    = name_length_reg;
        skip_remaining_next = skip_remaining_reg;
        files_seen_next     = files_seen_reg;
        stopped             = 1'b0;
        stop_status         = ST_DATA_END;
        name_emit           = 1'b0;
        size_new            = {in_byte, block_size_reg[7:0]};
        fix_total           = FILE_HDR_MIN + {1'b0, name_length_reg};
        size_rest           = block_size_reg - FILE_HDR_MIN[15:0] - name_length_reg;
        skip_calc           = {17'b0, size_rest} + {1'b0, packed_size_reg};
        name_dec            = name_length_reg - 16'd1;
        skip_dec            = (skip_remaining_reg != 33'd0) ? skip_remaining_reg - 33'd1
                                                            : skip_remaining_reg;
        if (in_valid)
        begin
            unique case (phase_reg)
                PH_SIG:
                begin
                    if (byte_index_reg >= SIG_LEN || in_byte != sig_byte(byte_index_reg[2:0]))
                    begin
                        stopped     = 1'b1;
                        stop_status = ST_BAD_SIG;
                    end
                    else if (byte_index_reg == SIG_LAST_IDX)
                    begin
                        byte_index_next = 5'd0;
                        phase_next      = PH_HDR;
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 5'd1;
                        if (in_last)
                        begin
                            stopped     = 1'b1;
                            stop_status = ST_BAD_SIG;
                        end
                    end
                end
                PH_HDR:
                begin
                    if (byte_index_reg == 5'd2)
                    begin
                        block_type_next = in_byte;
                        byte_index_next = byte_index_reg + 5'd1;
                        if (in_byte != TYPE_MAIN && in_byte != TYPE_FILE)
                        begin
                            stopped     = 1'b1;
                            stop_status = (in_byte == TYPE_END) ? ST_END_BLOCK : ST_UNKNOWN;
                        end
                    end
                    else if (byte_index_reg == 5'd5)
                    begin
                        block_size_next = {8'h00, in_byte};
                        byte_index_next = byte_index_reg + 5'd1;
                    end
                    else if (byte_index_reg >= 5'd6)
                    begin
                        block_size_next = size_new;
                        byte_index_next = 5'd0;
                        if (block_type_reg == TYPE_MAIN)
                        begin
                            if (size_new < BASE_LEN)
                            begin
                                stopped     = 1'b1;
                                stop_status = ST_MALFORMED;
                            end
                            else
                            begin
                                skip_remaining_next = {17'b0, size_new - BASE_LEN};
                                phase_next = (size_new == BASE_LEN) ? PH_HDR : PH_SKIP;
                            end
                        end
                        else if ({1'b0, size_new} < FILE_HDR_MIN)
                        begin
                            stopped     = 1'b1;
                            stop_status = ST_MALFORMED;
                        end
                        else
                        begin
                            packed_size_next = 32'd0;
                            name_length_next = 16'd0;
                            phase_next       = PH_FIX;
                        end
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 5'd1;
                    end
                end
                PH_FIX:
                begin
                    if (byte_index_reg < 5'd4)
                    begin
                        packed_size_next[{byte_index_reg[1:0], 3'b000} +: 8] = in_byte;
                        byte_index_next = byte_index_reg + 5'd1;
                    end
                    else if (byte_index_reg == 5'd19)
                    begin
                        name_length_next = {8'h00, in_byte};
                        byte_index_next  = byte_index_reg + 5'd1;
                    end
                    else if (byte_index_reg == 5'd20)
                    begin
                        name_length_next = {in_byte, name_length_reg[7:0]};
                        byte_index_next  = byte_index_reg + 5'd1;
                    end
                    else if (byte_index_reg >= FIX_LAST_IDX)
                    begin
                        byte_index_next = 5'd0;
                        if (fix_total > {1'b0, block_size_reg})
                        begin
                            stopped     = 1'b1;
                            stop_status = ST_MALFORMED;
                        end
                        else
                        begin
                            if (files_seen_reg != '1)
                            begin
                                files_seen_next = files_seen_reg + 1'b1;
                            end
                            skip_remaining_next = skip_calc;
                            if (name_length_reg != 16'd0)
                            begin
                                phase_next = PH_NAME;
                            end
                            else
                            begin
                                phase_next = (skip_calc == 33'd0) ? PH_HDR : PH_SKIP;
                            end
                        end
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 5'd1;
                    end
                end
                PH_NAME:
                begin
                    name_length_next = name_dec;
                    name_emit        = 1'b1;
                    if (name_dec == 16'd0)
                    begin
                        byte_index_next = 5'd0;
                        phase_next = (skip_remaining_reg == 33'd0) ? PH_HDR : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_remaining_next = skip_dec;
                    if (skip_dec == 33'd0)
                    begin
                        byte_index_next = 5'd0;
                        phase_next      = PH_HDR;
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase

            // The final byte closes the walk unless it already stopped.
            if (!stopped && in_last && phase_reg != PH_DONE)
            begin
                stopped     = 1'b1;
                stop_status = ST_DATA_END;
            end
            if (stopped)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    // Result items: a name byte and/or the closing summary.
    always_comb
    begin
        name_res.kind       = KIND_NAME;
        name_res.name_byte  = in_byte;
        name_res.name_end   = (name_dec == 16'd0);
        name_res.file_count = shown_count(files_seen_reg);
        name_res.status     = ST_END_BLOCK;
        name_res.last       = 1'b0;

        sum_res.kind        = KIND_SUMMARY;
        sum_res.name_byte   = 8'h00;
        sum_res.name_end    = 1'b0;
        sum_res.file_count  = shown_count(files_seen_next);
        sum_res.status      = stop_status;
        sum_res.last        = 1'b1;

        push.wr0  = name_emit || stopped;
        push.wr1  = name_emit && stopped;
        push.res0 = name_emit ? name_res : sum_res;
        push.res1 = sum_res;
    end

    // Walk state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_SIG;
            byte_index_reg     <= 5'd0;
            block_type_reg     <= 8'd0;
            block_size_reg     <= 16'd0;
            packed_size_reg    <= 32'd0;
            name_length_reg    <= 16'd0;
            skip_remaining_reg <= 33'd0;
            files_seen_reg     <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            byte_index_reg     <= byte_index_next;
            block_type_reg     <= block_type_next;
            block_size_reg     <= block_size_next;
            packed_size_reg    <= packed_size_next;
            name_length_reg    <= name_length_next;
            skip_remaining_reg <= skip_remaining_next;
            files_seen_reg     <= files_seen_next;
        end
    end

    // Once the summary has gone out, the walk never resumes.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("walk left the finished phase");

    // No result is produced after the summary.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && phase_reg == PH_DONE) |-> !push.wr0)
        else $error("result produced after the summary");

    // Two results from one byte only when a name byte is also the final byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.wr1 |-> (push.wr0 && in_last && phase_reg == PH_NAME))
        else $error("second result without a final name byte");

    // The signature position never runs past the signature.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SIG |-> byte_index_reg < SIG_LEN)
        else $error("signature index out of range");

endmodule

@@ rtl/core/awk_out_q.sv @@
// Small result queue that takes up to two results a cycle and hands one out on out_ready.
module awk_out_q (
    input  logic              clk,
    input  logic              rst_n,
    input  awk_pkg::push_t    push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output awk_pkg::result_t  out_res
);
    import awk_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;
    logic               pop;
    logic [CNT_W-1:0]   n_in;

    // Room for a full pair of results keeps the input side independent of this cycle's read.
    assign room      = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill level bookkeeping.
    always_comb
    begin
        wr_ptr_plus1 = wr_ptr_reg + 1'b1;
        n_in         = CNT_W'(push.wr0) + CNT_W'(push.wr1);
        wr_ptr_next  = wr_ptr_reg + PTR_W'(n_in);
        rd_ptr_next  = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg + n_in - CNT_W'(pop);
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push.wr0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.wr1)
        begin
            mem[wr_ptr_plus1] <= push.res1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ test/archive_block_header_walker_unit_test.sv @@
// Self-checking testbench for the archive block header walker: a byte stream in, name and summary results out.
module archive_block_header_walker_unit_test;
    import awk_pkg::*;

    // Run length and flow-control settings.
    localparam int          STREAM_TARGET = 500;
    localparam int          HOLD_OFF      = 80;
    localparam int          DRAIN_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [55:0] SIG_PATTERN   = 56'h00_07_1A_21_72_61_52;
    localparam logic [2:0]  NO_STATUS     = 3'd0;

    // Phases of the walk as the predictor tracks them.
    typedef enum logic [2:0] {
        WALK_SIG,
        WALK_HDR,
        WALK_FIX,
        WALK_NAME,
        WALK_SKIP,
        WALK_DONE
    } walk_phase_t;

    // One byte of the archive stream together with its end marker.
    typedef struct packed {
        logic [7:0] value;
        logic       eod;
    } stream_byte_t;

    // Predicts the walker's results and compares them with what leaves the block.
    class walk_predictor;
        walk_phase_t            phase;
        int unsigned            idx;
        logic [7:0]             btype;
        logic [15:0]            bsize;
        logic [31:0]            psize;
        logic [15:0]            nlen;
        logic [32:0]            skip;
        logic [COUNT_WIDTH-1:0] files;
        bit                     finished;
        result_t                due_records[$];
        int                     errors;

        function new();
            phase    = WALK_SIG;
            idx      = 0;
            btype    = '0;
            bsize    = '0;
            psize    = '0;
            nlen     = '0;
            skip     = '0;
            files    = '0;
            finished = 1'b0;
            errors   = 0;
        endfunction

        function int pending();
            return due_records.size();
        endfunction

        function void add_record(logic kind, logic [7:0] nb, logic ne, logic [2:0] st,
                                 logic lst);
            result_t    r;
            logic [63:0] wide;
            wide         = 64'(files);
            r.kind       = kind;
            r.name_byte  = nb;
            r.name_end   = ne;
            r.file_count = (wide > 64'hFFFF) ? 16'hFFFF : wide[15:0];
            r.status     = st;
            r.last       = lst;
            due_records.push_back(r);
        endfunction

        function void stop(logic [2:0] st);
            add_record(KIND_SUMMARY, 8'h00, 1'b0, st, 1'b1);
            finished = 1'b1;
            phase    = WALK_DONE;
        endfunction

        function void next_block();
            idx   = 0;
            phase = (skip == '0) ? WALK_HDR : WALK_SKIP;
        endfunction

        // Advance the walk by one accepted input transaction.
        function void note_byte(logic [7:0] b, logic eod);
            if (finished)
            begin
                return;
            end
            case (phase)
                WALK_SIG:
                begin
                    if (b != SIG_PATTERN[8*idx +: 8])
                    begin
                        stop(ST_BAD_SIG);
                    end
                    else
                    begin
                        idx++;
                        if (idx == SIG_LEN)
                        begin
                            idx   = 0;
                            phase = WALK_HDR;
                        end
                        else if (eod)
                        begin
                            stop(ST_BAD_SIG);
                        end
                    end
                end
                WALK_HDR:
                begin
                    if (idx == 2)
                    begin
                        btype = b;
                        if (b != TYPE_MAIN && b != TYPE_FILE)
                        begin
                            stop((b == TYPE_END) ? ST_END_BLOCK : ST_UNKNOWN);
                        end
                        else
                        begin
                            idx++;
                        end
                    end
                    else if (idx == 5)
                    begin
                        bsize = {8'h00, b};
                        idx++;
                    end
                    else if (idx >= 6)
                    begin
                        bsize = {b, bsize[7:0]};
                        idx   = 0;
                        if (btype == TYPE_MAIN)
                        begin
                            if (bsize < BASE_LEN)
                            begin
                                stop(ST_MALFORMED);
                            end
                            else
                            begin
                                skip = 33'(bsize - BASE_LEN);
                                next_block();
                            end
                        end
                        else if (17'(bsize) < FILE_HDR_MIN)
                        begin
                            stop(ST_MALFORMED);
                        end
                        else
                        begin
                            psize = '0;
                            nlen  = '0;
                            phase = WALK_FIX;
                        end
                    end
                    else
                    begin
                        idx++;
                    end
                end
                WALK_FIX:
                begin
                    if (idx < 4)
                    begin
                        psize[8*idx +: 8] = b;
                        idx++;
                    end
                    else if (idx == 19)
                    begin
                        nlen = {8'h00, b};
                        idx++;
                    end
                    else if (idx == 20)
                    begin
                        nlen[15:8] = b;
                        idx++;
                    end
                    else if (idx >= FIX_LAST_IDX)
                    begin
                        idx = 0;
                        if (FILE_HDR_MIN + 17'(nlen) > 17'(bsize))
                        begin
                            stop(ST_MALFORMED);
                        end
                        else
                        begin
                            if (files != {COUNT_WIDTH{1'b1}})
                            begin
                                files++;
                            end
                            skip = 33'(bsize) - 33'(FILE_HDR_MIN) - 33'(nlen) + 33'(psize);
                            if (nlen != '0)
                            begin
                                phase = WALK_NAME;
                            end
                            else
                            begin
                                next_block();
                            end
                        end
                    end
                    else
                    begin
                        idx++;
                    end
                end
                WALK_NAME:
                begin
                    nlen = nlen - 16'd1;
                    add_record(KIND_NAME, b, nlen == '0, NO_STATUS, 1'b0);
                    if (nlen == '0)
                    begin
                        next_block();
                    end
                end
                WALK_SKIP:
                begin
                    if (skip != '0)
                    begin
                        skip = skip - 33'd1;
                    end
                    if (skip == '0)
                    begin
                        next_block();
                    end
                end
                default:
                begin
                end
            endcase
            if (!finished && eod)
            begin
                stop(ST_DATA_END);
            end
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        // Compare one result transaction with the oldest prediction.
        function void check_result(logic [TDATA_W-1:0] data, logic user, logic lst);
            result_t want;
            if (due_records.size() == 0)
            begin
                $error("result transaction with nothing predicted: tdata 0x%0h", data);
                errors++;
                return;
            end
            want = due_records.pop_front();
            compare("kind", want.kind, user);
            compare("name_byte", want.name_byte, data[7:0]);
            compare("name_end", want.name_end, data[8]);
            compare("file_count", want.file_count, data[24:9]);
            compare("status", want.status, data[27:25]);
            compare("last", want.last, lst);
            compare("tdata padding", '0, data[TDATA_W-1 -: TDATA_PAD]);
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    walk_predictor       sb;
    stream_byte_t        stim_q[$];

    archive_block_header_walker_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // Idle length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void push_byte(logic [7:0] v, logic eod = 1'b0);
        stim_q.push_back({v, eod});
    endfunction

    function automatic void push_rand(int n);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_signature();
        for (int i = 0; i < SIG_LEN; i++)
        begin
            push_byte(SIG_PATTERN[8*i +: 8]);
        end
    endfunction

    // Seven-byte base header: check word, type, flags, little-endian size.
    function automatic void push_base(logic [7:0] btype, logic [15:0] size);
        push_rand(2);
        push_byte(btype);
        push_rand(2);
        push_byte(size[7:0]);
        push_byte(size[15:8]);
    endfunction

    function automatic void push_main(logic [15:0] size);
        push_base(TYPE_MAIN, size);
        push_rand(int'(size) - int'(BASE_LEN));
    endfunction

    // Base header plus the fixed part of a file header.
    function automatic void push_file_head(logic [15:0] hsize, logic [15:0] name_len,
                                           logic [31:0] data_len);
        push_base(TYPE_FILE, hsize);
        for (int i = 0; i <= FIX_LAST_IDX; i++)
        begin
            if (i < 4)
            begin
                push_byte(data_len[8*i +: 8]);
            end
            else if (i == 19)
            begin
                push_byte(name_len[7:0]);
            end
            else if (i == 20)
            begin
                push_byte(name_len[15:8]);
            end
            else
            begin
                push_rand(1);
            end
        end
    endfunction

    // Well-formed file header, its name, spare header bytes and packed data.
    function automatic void push_file(int name_len, int spare, int data_len);
        push_file_head(16'(int'(FILE_HDR_MIN) + name_len + spare), 16'(name_len),
                       32'(data_len));
        push_rand(name_len + spare + data_len);
    endfunction

    function automatic void push_random_block();
        if ($urandom_range(0, 3) == 0)
        begin
            push_main(16'(int'(BASE_LEN) + $urandom_range(0, 5)));
        end
        else
        begin
            push_file(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12),
                      $urandom_range(0, 3), $urandom_range(0, 6));
        end
    endfunction

    // A stream that breaks off inside the signature.
    function automatic void push_signature_fault();
        int k;
        int mode;
        logic [7:0] wrong;
        mode = $urandom_range(0, 2);
        k    = $urandom_range(0, SIG_LEN - 1);
        for (int i = 0; i < k; i++)
        begin
            push_byte(SIG_PATTERN[8*i +: 8]);
        end
        if (mode == 0)
        begin
            // Wrong byte at position k.
            do
            begin
                wrong = 8'($urandom_range(0, 255));
            end
            while (wrong == SIG_PATTERN[8*k +: 8]);
            push_byte(wrong);
        end
        else if (mode == 1 && k < SIG_LEN - 1)
        begin
            // Data ends before the signature is complete.
            push_byte(SIG_PATTERN[8*k +: 8], 1'b1);
        end
        else
        begin
            // Data ends right after the signature.
            for (int i = k; i < SIG_LEN - 1; i++)
            begin
                push_byte(SIG_PATTERN[8*i +: 8]);
            end
            push_byte(SIG_PATTERN[8*(SIG_LEN-1) +: 8], 1'b1);
        end
    endfunction

    // Close the walk in one of the ways it can stop.
    function automatic void push_ending();
        int start;
        int pos;
        int spare;
        logic [7:0] btype;
        start = stim_q.size();
        case ($urandom_range(0, 5))
            0:
            begin
                push_base(TYPE_END, 16'($urandom_range(0, 65535)));
                // The type byte may carry the end marker as well; the end block wins.
                if ($urandom_range(0, 1) == 1)
                begin
                    stim_q[start + 2].eod = 1'b1;
                end
            end
            1:
            begin
                do
                begin
                    btype = 8'($urandom_range(0, 255));
                end
                while (btype == TYPE_MAIN || btype == TYPE_FILE || btype == TYPE_END);
                push_base(btype, 16'($urandom_range(0, 65535)));
            end
            2:
            begin
                // Data ends at any byte of an ordinary block.
                push_random_block();
                pos = start + $urandom_range(0, stim_q.size() - start - 1);
                while (stim_q.size() > pos + 1)
                begin
                    void'(stim_q.pop_back());
                end
                stim_q[pos].eod = 1'b1;
            end
            3:
            begin
                push_base(TYPE_MAIN, 16'($urandom_range(0, int'(BASE_LEN) - 1)));
            end
            4:
            begin
                push_base(TYPE_FILE, 16'($urandom_range(0, int'(FILE_HDR_MIN) - 1)));
            end
            default:
            begin
                // Name size larger than the header leaves room for.
                if ($urandom_range(0, 2) == 0)
                begin
                    push_file_head(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
                end
                else
                begin
                    spare = $urandom_range(0, 4);
                    push_file_head(16'(int'(FILE_HDR_MIN) + spare),
                                   16'(spare + $urandom_range(1, 4)), 32'd0);
                end
            end
        endcase
    endfunction

    function automatic void build_stimulus();
        if ($urandom_range(0, 11) == 0)
        begin
            push_signature_fault();
        end
        else
        begin
            // Directed opening: header boundaries, extreme byte values, empty and long names.
            push_signature();
            push_main(BASE_LEN);
            push_base(TYPE_MAIN, 16'd9);
            push_byte(8'h00);
            push_byte(8'hFF);
            push_file(40, 2, 3);
            push_file(0, 0, 0);
            push_file(1, 0, 0);
            push_file(0, 3, 2);
            while (stim_q.size() < STREAM_TARGET)
            begin
                push_random_block();
            end
            push_ending();
        end
        // Bytes after the summary are ignored by the block; a short stream is topped up
        // so that every run offers about the same number of transactions.
        repeat (12) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        while (stim_q.size() < STREAM_TARGET)
        begin
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endfunction

    // Offer one byte and hold it until accepted, then idle for the given gap.
    task automatic send_byte(stream_byte_t item, int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= item.value;
        s_tlast  <= item.eod;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Observe both sides at each edge: inputs are noted before results are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata, m_tuser, m_tlast);
            end
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off once results are due.
    initial
    begin
        bit held;
        bit quiet;
        int stall;
        int round;
        held  = 1'b0;
        quiet = 1'b0;
        round = 0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (!held && sb.pending() != 0)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            round++;
            if (round % 32 == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            stall = quiet ? 0 : pick_gap();
            if (stall == 0)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Guard against a hung run.
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    // Reset, stream the archive, drain the results and report.
    initial
    begin
        bit quiet;
        int drain;
        quiet = 1'b0;
        drain = 0;
        sb    = new();
        build_stimulus();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (stim_q[i])
        begin
            if (i % 40 == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            send_byte(stim_q[i], quiet ? 0 : pick_gap());
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d predicted result transactions never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ archive_block_header_walker_unit.f @@
rtl/core/awk_pkg.sv
rtl/core/awk_parser.sv
rtl/core/awk_out_q.sv
rtl/core/archive_block_header_walker_unit.sv
test/archive_block_header_walker_unit_test.sv
